// ===== design/irn_pkg.sv =====
package irn_pkg;

    localparam int VALUE_W   = 12;
    localparam int SYM_W     = 8;
    localparam int TOK_COUNT = 13;
    localparam int TOK_IDX_W = $clog2(TOK_COUNT);

    localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd3999;

    typedef logic [TOK_IDX_W-1:0] tok_idx_t;

    // ASCII letters
    localparam logic [SYM_W-1:0] CHAR_NONE = 8'h00;
    localparam logic [SYM_W-1:0] CHAR_I    = 8'h49;
    localparam logic [SYM_W-1:0] CHAR_V    = 8'h56;
    localparam logic [SYM_W-1:0] CHAR_X    = 8'h58;
    localparam logic [SYM_W-1:0] CHAR_L    = 8'h4C;
    localparam logic [SYM_W-1:0] CHAR_C    = 8'h43;
    localparam logic [SYM_W-1:0] CHAR_D    = 8'h44;
    localparam logic [SYM_W-1:0] CHAR_M    = 8'h4D;

    localparam logic [VALUE_W-1:0] TOK_VALUE [TOK_COUNT] = '{
        12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
        12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
    };
    localparam logic [SYM_W-1:0] TOK_FIRST [TOK_COUNT] = '{
        CHAR_M, CHAR_C, CHAR_D, CHAR_C, CHAR_C, CHAR_X, CHAR_L,
        CHAR_X, CHAR_X, CHAR_I, CHAR_V, CHAR_I, CHAR_I
    };
    localparam logic [SYM_W-1:0] TOK_SECOND [TOK_COUNT] = '{
        CHAR_NONE, CHAR_M, CHAR_NONE, CHAR_D, CHAR_NONE, CHAR_C, CHAR_NONE,
        CHAR_L, CHAR_NONE, CHAR_X, CHAR_NONE, CHAR_V, CHAR_NONE
    };

    typedef struct packed {
        logic load;     // take s_value into the datapath
        logic step;     // emit one beat into the output register
    } irn_cmd_t;

    typedef struct packed {
        logic out_free;   // output register empty or being drained
        logic step_last;  // the beat produced this cycle closes the numeral
    } irn_sts_t;

    // Largest token not above rem. Tokens are descending, so the lowest
    // matching index wins; the loop runs high to low and keeps the last hit.
    function automatic tok_idx_t tok_pick(logic [VALUE_W-1:0] rem);
        tok_idx_t pick;
        pick = '0;
        for (int i = TOK_COUNT - 1; i >= 0; i--) begin
            if (rem >= TOK_VALUE[i]) begin
                pick = tok_idx_t'(i);
            end
        end
        return pick;
    endfunction

endpackage

// ===== design/irn_ctrl.sv =====
module irn_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  irn_pkg::irn_sts_t sts,
    output irn_pkg::irn_cmd_t cmd
);
    import irn_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg;
    logic   s_ready_reg;

    assign s_ready  = s_ready_reg;
    assign cmd.load = s_valid && s_ready_reg;
    assign cmd.step = (state_reg == ST_RUN) && sts.out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (cmd.load) begin
                        state_reg   <= ST_RUN;
                        s_ready_reg <= 1'b0;
                    end
                end
                ST_RUN: begin
                    if (cmd.step && sts.step_last) begin
                        state_reg   <= ST_IDLE;
                        s_ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg   <= ST_IDLE;
                    s_ready_reg <= 1'b1;
                end
            endcase
        end
    end

endmodule

// ===== design/irn_dp.sv =====
module irn_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [irn_pkg::VALUE_W-1:0] s_value,
    input  irn_pkg::irn_cmd_t           cmd,
    output irn_pkg::irn_sts_t           sts,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [irn_pkg::SYM_W-1:0]   m_symbol,
    output logic                        m_last,
    output logic                        m_empty_res,
    output logic                        m_error
);
    import irn_pkg::*;

    typedef enum logic [1:0] {
        KIND_NORMAL,
        KIND_ZERO,
        KIND_ERROR
    } kind_t;

    logic [VALUE_W-1:0] remaining_reg, remaining_next;
    logic [SYM_W-1:0]   pending_char_reg, pending_char_next;
    logic               pending_valid_reg, pending_valid_next;
    kind_t              kind_reg, kind_next;

    logic               m_valid_reg, m_valid_next;
    logic [SYM_W-1:0]   m_symbol_reg, m_symbol_next;
    logic               m_last_reg, m_last_next;
    logic               m_empty_res_reg, m_empty_res_next;
    logic               m_error_reg, m_error_next;

    tok_idx_t           tok_idx;
    logic [VALUE_W-1:0] rem_sub;

    // beat built this cycle
    logic [SYM_W-1:0]   beat_sym;
    logic               beat_last;
    logic               beat_empty;
    logic               beat_error;

    assign tok_idx = tok_pick(remaining_reg);
    assign rem_sub = remaining_reg - TOK_VALUE[tok_idx];

    always_comb begin
        beat_sym           = CHAR_NONE;
        beat_last          = 1'b1;
        beat_empty         = 1'b0;
        beat_error         = 1'b0;
        remaining_next     = remaining_reg;
        pending_char_next  = pending_char_reg;
        pending_valid_next = pending_valid_reg;
        unique case (kind_reg)
            KIND_ZERO:  beat_empty = 1'b1;
            KIND_ERROR: beat_error = 1'b1;
            KIND_NORMAL: begin
                if (pending_valid_reg) begin
                    beat_sym           = pending_char_reg;
                    beat_last          = (remaining_reg == '0);
                    pending_valid_next = 1'b0;
                end else begin
                    beat_sym           = TOK_FIRST[tok_idx];
                    remaining_next     = rem_sub;
                    pending_char_next  = TOK_SECOND[tok_idx];
                    pending_valid_next = (TOK_SECOND[tok_idx] != CHAR_NONE);
                    beat_last          = (TOK_SECOND[tok_idx] == CHAR_NONE) &&
                                         (rem_sub == '0);
                end
            end
            default: beat_error = 1'b1;
        endcase

        kind_next = kind_reg;
        if (cmd.load) begin
            remaining_next     = s_value;
            pending_valid_next = 1'b0;
            if (s_value == '0) begin
                kind_next = KIND_ZERO;
            end else if (s_value > MAX_VALUE) begin
                kind_next = KIND_ERROR;
            end else begin
                kind_next = KIND_NORMAL;
            end
        end else if (!cmd.step) begin
            remaining_next     = remaining_reg;
            pending_char_next  = pending_char_reg;
            pending_valid_next = pending_valid_reg;
        end
    end

    assign sts.out_free  = !m_valid_reg || m_ready;
    assign sts.step_last = beat_last;

    always_comb begin
        m_valid_next     = m_valid_reg && !m_ready;
        m_symbol_next    = m_symbol_reg;
        m_last_next      = m_last_reg;
        m_empty_res_next = m_empty_res_reg;
        m_error_next     = m_error_reg;
        if (cmd.step) begin
            m_valid_next     = 1'b1;
            m_symbol_next    = beat_sym;
            m_last_next      = beat_last;
            m_empty_res_next = beat_empty;
            m_error_next     = beat_error;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg       <= 1'b0;
            pending_valid_reg <= 1'b0;
        end else begin
            m_valid_reg       <= m_valid_next;
            pending_valid_reg <= pending_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        remaining_reg    <= remaining_next;
        pending_char_reg <= pending_char_next;
        kind_reg         <= kind_next;
        m_symbol_reg     <= m_symbol_next;
        m_last_reg       <= m_last_next;
        m_empty_res_reg  <= m_empty_res_next;
        m_error_reg      <= m_error_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_symbol    = m_symbol_reg;
    assign m_last      = m_last_reg;
    assign m_empty_res = m_empty_res_reg;
    assign m_error     = m_error_reg;

`ifndef SYNTH
    a_flag_is_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_empty_res_reg || m_error_reg) |-> m_last_reg)
        else $error("flagged beat without last");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_empty_res_reg && m_error_reg))
        else $error("empty and error both set");

    a_flag_no_symbol: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_empty_res_reg || m_error_reg) |-> m_symbol_reg == CHAR_NONE)
        else $error("flagged beat carries a symbol");

    a_pending_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_valid_reg && cmd.step && !cmd.load |=> !pending_valid_reg)
        else $error("second letter not consumed");
`endif

endmodule

// ===== design/integer_to_roman_numeral.sv =====
// Integer to Roman numeral: one 12-bit value in, one ASCII letter per beat out.
// Beats: n = 1..15 letters per value (a single beat for zero or error); the letter
// sequencer emits one beat per cycle into the output reg while it is free, and s_ready
// stays low until the last beat of a value has been emitted.
// Reset: aresetn synchronous active low; clears the sequencer and output valid.
module integer_to_roman_numeral (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [irn_pkg::VALUE_W-1:0] s_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [irn_pkg::SYM_W-1:0]   m_symbol,
    output logic                        m_last,
    output logic                        m_empty_res,
    output logic                        m_error
);
    import irn_pkg::*;

    irn_cmd_t cmd;
    irn_sts_t sts;

    irn_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    irn_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_value     (s_value),
        .cmd         (cmd),
        .sts         (sts),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_symbol    (m_symbol),
        .m_last      (m_last),
        .m_empty_res (m_empty_res),
        .m_error     (m_error)
    );

endmodule

// ===== sim/roman_letter_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels, spells each accepted value as Roman letters and
// compares every result beat against the oldest letter still due.
module roman_letter_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [irn_pkg::VALUE_W-1:0] s_value,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [irn_pkg::SYM_W-1:0]   m_symbol,
    input  logic                        m_last,
    input  logic                        m_empty_res,
    input  logic                        m_error,
    output int                          fail_count,
    output int                          pending
);
    import irn_pkg::*;

    typedef struct packed {
        logic [VALUE_W-1:0] src;    // value that produced this letter, for messages
        logic [SYM_W-1:0]   symbol;
        logic               last;
        logic               empty_res;
        logic               error;
    } letter_t;

    localparam int NUMERAL_VAL [13] = '{
        1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1
    };
    localparam logic [SYM_W-1:0] LEAD_CH [13] = '{
        CHAR_M, CHAR_C, CHAR_D, CHAR_C, CHAR_C, CHAR_X, CHAR_L,
        CHAR_X, CHAR_X, CHAR_I, CHAR_V, CHAR_I, CHAR_I
    };
    localparam logic [SYM_W-1:0] TRAIL_CH [13] = '{
        CHAR_NONE, CHAR_M, CHAR_NONE, CHAR_D, CHAR_NONE, CHAR_C, CHAR_NONE,
        CHAR_L, CHAR_NONE, CHAR_X, CHAR_NONE, CHAR_V, CHAR_NONE
    };

    letter_t letters_due[$];

    // Greedy spelling; a two-letter token such as CM becomes two beats.
    function automatic void spell_roman(input logic [VALUE_W-1:0] v);
        int      rem;
        letter_t ltr;
        ltr = '0;
        ltr.src = v;
        if (v == '0) begin
            ltr.last = 1'b1;
            ltr.empty_res = 1'b1;
            letters_due.push_back(ltr);
        end else if (v > MAX_VALUE) begin
            ltr.last = 1'b1;
            ltr.error = 1'b1;
            letters_due.push_back(ltr);
        end else begin
            rem = int'(v);
            for (int i = 0; i < 13; i++) begin
                while (rem >= NUMERAL_VAL[i]) begin
                    ltr.symbol = LEAD_CH[i];
                    letters_due.push_back(ltr);
                    if (TRAIL_CH[i] != CHAR_NONE) begin
                        ltr.symbol = TRAIL_CH[i];
                        letters_due.push_back(ltr);
                    end
                    rem -= NUMERAL_VAL[i];
                end
            end
            letters_due[letters_due.size() - 1].last = 1'b1;
        end
    endfunction

    always @(posedge aclk) begin
        letter_t want;
        if (!aresetn) begin
            letters_due.delete();
            fail_count = 0;
            pending <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (letters_due.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("%0t: result beat with nothing due: %s %h %b %b %b",
                                 $time, "sym/last/empty/err", m_symbol, m_last,
                                 m_empty_res, m_error);
                    end
                    fail_count = fail_count + 1;
                end else begin
                    want = letters_due.pop_front();
                    if (m_symbol !== want.symbol || m_last !== want.last ||
                        m_empty_res !== want.empty_res || m_error !== want.error) begin
                        if (fail_count < 10) begin
                            $display("%0t: value %0d: expected sym %h last %b empty %b err %b",
                                     $time, want.src, want.symbol, want.last,
                                     want.empty_res, want.error);
                            $display("    got sym %h last %b empty %b err %b",
                                     m_symbol, m_last, m_empty_res, m_error);
                        end
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (s_valid && s_ready) begin
                spell_roman(s_value);
            end
            pending <= letters_due.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import irn_pkg::*;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [VALUE_W-1:0] s_value;
    logic               m_valid;
    logic               m_ready;
    logic [SYM_W-1:0]   m_symbol;
    logic               m_last;
    logic               m_empty_res;
    logic               m_error;
    int                 fail_count;
    int                 pending;

    bit quiet;      // no idling on either side
    bit hold_req;   // ask the receiver for one long stall

    integer_to_roman_numeral u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_symbol    (m_symbol),
        .m_last      (m_last),
        .m_empty_res (m_empty_res),
        .m_error     (m_error)
    );

    roman_letter_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_symbol    (m_symbol),
        .m_last      (m_last),
        .m_empty_res (m_empty_res),
        .m_error     (m_error),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Mostly in-range numerals, leaning toward long ones; some zero and overflow.
    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r <= 2) return VALUE_W'($urandom_range(4000, 4095));
        if (r <= 6) return VALUE_W'($urandom_range(3000, 3999));
        return VALUE_W'($urandom_range(1, 3999));
    endfunction

    task automatic send_value(input logic [VALUE_W-1:0] v);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 11);
        end
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Receiver: random ready runs and stall bursts, plus one long hold-off.
    initial begin
        int run_left;
        int stall_left;
        bit hold_done;
        m_ready = 1'b0;
        run_left = 0;
        stall_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                stall_left = 300;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (quiet) begin
                m_ready <= 1'b1;
            end else if (run_left > 0) begin
                run_left--;
                m_ready <= 1'b1;
            end else if ($urandom_range(0, 2) == 0) begin
                stall_left = $urandom_range(1, 11) - 1;
                m_ready <= 1'b0;
            end else begin
                run_left = $urandom_range(1, 20) - 1;
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [VALUE_W-1:0] corner_values [22];
        corner_values = '{
            12'd0, 12'd4095, 12'd4000, 12'd3999, 12'd3888, 12'd1, 12'd4, 12'd9,
            12'd40, 12'd90, 12'd400, 12'd900, 12'd1000, 12'd3, 12'd8, 12'd49,
            12'd444, 12'd1994, 12'd2048, 12'd2730, 12'd1365, 12'd3000
        };
        s_valid = 1'b0;
        s_value = '0;
        aresetn = 1'b0;
        quiet = 1'b0;
        hold_req = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (corner_values[i]) begin
            send_value(corner_values[i]);
        end

        for (int i = 0; i < 88; i++) begin
            if (i == 10) hold_req = 1'b1;
            if (i == 70) quiet = 1'b1;
            if (i == 40) begin
                // let the block drain completely before going on
                @(negedge aclk);
                s_valid <= 1'b0;
                while (pending != 0) @(negedge aclk);
            end
            send_value(pick_value());
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("integer_to_roman_numeral regression: pass");
        end else begin
            $display("integer_to_roman_numeral regression: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("integer_to_roman_numeral regression: fail");
        $finish;
    end

endmodule
